/* sv/s2cd_pkg.sv */
// Shared types, constants and tables for the seconds-to-calendar-date unit.
`timescale 1ns / 1ps

package s2cd_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned EpochDaynum = 727869;  // March-based day number of 1993-01-01
  localparam int unsigned Days400Y    = 146097;
  localparam int unsigned Days100Y    = 36524;
  localparam int unsigned Days4Y      = 1461;
  localparam int unsigned Days1Y      = 365;
  localparam int unsigned Days5Mon    = 153;

  // Reciprocals: m = ceil(2^k / d), exact for x < 2^N with k = N + ceil(log2 d)
  localparam int unsigned Div675Shift = 35;
  localparam logic [63:0] Div675Recip = ((64'd1 << Div675Shift) + 64'd674) / 64'd675;
  localparam int unsigned Div60RemShift = 23;
  localparam logic [63:0] Div60RemRecip = ((64'd1 << Div60RemShift) + 64'd59) / 64'd60;
  localparam int unsigned Div60MinShift = 17;
  localparam logic [63:0] Div60MinRecip = ((64'd1 << Div60MinShift) + 64'd59) / 64'd60;
  localparam int unsigned Div1461Shift = 31;
  localparam logic [63:0] Div1461Recip = ((64'd1 << Div1461Shift) + 64'd1460) / 64'd1461;
  localparam int unsigned Div365Shift = 29;
  localparam logic [63:0] Div365Recip = ((64'd1 << Div365Shift) + 64'd364) / 64'd365;
  localparam int unsigned Div305Shift = 20;
  localparam logic [63:0] Div305Recip = ((64'd1 << Div305Shift) + 64'd304) / 64'd305;

  // Register stages of the day-number-to-date path; time of day is padded to match.
  localparam int unsigned CivilLatency = 10;
  localparam int unsigned TodStages    = 3;

  typedef struct packed {
    logic [19:0] daynum;
    logic [16:0] rem;
  } split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } date_t;

  // First day of March-based month: (mo * 306 + 5) / 10
  function automatic logic [8:0] month_start(input logic [3:0] mo);
    logic [8:0] res;
    unique case (mo)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* sv/s2cd_day_split.sv */
// Splits a seconds count into a March-based day number and seconds within the day.
`timescale 1ns / 1ps

module s2cd_day_split (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [31:0]           secs_i,
  output logic                  valid_o,
  output s2cd_pkg::split_t      split_o
);

  logic        vld1_q, vld2_q;
  logic [15:0] days_d, days_q;
  logic [31:0] secs_q;
  logic [50:0] div_prod;
  logic [32:0] day_secs;
  s2cd_pkg::split_t split_d, split_q;

  // secs / 86400 = (secs >> 7) / 675
  assign div_prod = 51'(secs_i[31:7]) * 51'(s2cd_pkg::Div675Recip[25:0]);
  assign days_d   = div_prod[s2cd_pkg::Div675Shift +: 16];

  assign day_secs       = 33'(days_q) * 33'(s2cd_pkg::SecsPerDay);
  assign split_d.rem    = 17'(secs_q - day_secs[31:0]);
  assign split_d.daynum = 20'(days_q) + 20'(s2cd_pkg::EpochDaynum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q  <= days_d;
    secs_q  <= secs_i;
    split_q <= split_d;
  end

  assign valid_o = vld2_q;
  assign split_o = split_q;

endmodule

/* sv/s2cd_tod.sv */
// Hour, minute and second from seconds within the day, padded to the date latency.
`timescale 1ns / 1ps

module s2cd_tod (
  input  logic              clk_i,
  input  logic [16:0]       rem_i,
  output s2cd_pkg::tod_t    tod_o
);

  localparam int unsigned PadDepth = s2cd_pkg::CivilLatency - s2cd_pkg::TodStages;

  logic [34:0] min_prod;
  logic [22:0] hour_prod;
  logic [16:0] rem_q;
  logic [10:0] totmin_d, totmin_q, totmin4_q;
  logic [16:0] min_secs;
  logic [10:0] hour_mins;
  logic [4:0]  hour_d, hour_q;
  logic [5:0]  sec_d, sec_q;
  s2cd_pkg::tod_t tod_d;
  s2cd_pkg::tod_t pad_q [PadDepth+1];

  assign min_prod = 35'(rem_i) * 35'(s2cd_pkg::Div60RemRecip[17:0]);
  assign totmin_d = min_prod[s2cd_pkg::Div60RemShift +: 11];

  assign hour_prod = 23'(totmin_q) * 23'(s2cd_pkg::Div60MinRecip[11:0]);
  assign hour_d    = hour_prod[s2cd_pkg::Div60MinShift +: 5];
  assign min_secs  = 17'(totmin_q) * 17'd60;
  assign sec_d     = 6'(rem_q - min_secs);

  assign hour_mins    = 11'(hour_q) * 11'd60;
  assign tod_d.hour   = hour_q;
  assign tod_d.minute = 6'(totmin4_q - hour_mins);
  assign tod_d.second = sec_q;

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_i;
    totmin_q  <= totmin_d;
    hour_q    <= hour_d;
    sec_q     <= sec_d;
    totmin4_q <= totmin_q;
    pad_q[0]  <= tod_d;
    for (int i = 1; i <= PadDepth; i++) begin
      pad_q[i] <= pad_q[i-1];
    end
  end

  assign tod_o = pad_q[PadDepth];

endmodule

/* sv/s2cd_civil.sv */
// March-based day number to Gregorian year, month and day of month.
`timescale 1ns / 1ps

module s2cd_civil (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [19:0]       daynum_i,
  output logic              valid_o,
  output s2cd_pkg::date_t   date_o
);

  logic [s2cd_pkg::CivilLatency-1:0] vld_q;

  // stage 3..12 registers
  logic [19:0] t0_q, dn3_q;
  logic [19:0] t1_q, dn4_q;
  logic [9:0]  q4_q;
  logic [19:0] t1b_q, dn5_q;
  logic [19:0] t2_q, dn6_q;
  logic [11:0] yr7_q;
  logic [19:0] dn7_q;
  logic [19:0] p8_q, dn8_q;
  logic [9:0]  corr8_q;
  logic [11:0] yr8_q;
  logic [8:0]  doy9_q;
  logic [11:0] yr9_q;
  logic [1:0]  q10_q;
  logic [7:0]  r10_q;
  logic [8:0]  doy10_q;
  logic [11:0] yr10_q;
  logic [3:0]  mo11_q;
  logic [8:0]  doy11_q;
  logic [11:0] yr11_q;
  s2cd_pkg::date_t date_d, date_q;

  logic [2:0]  q400;
  logic [4:0]  q100;
  logic [19:0] x1461;
  logic [40:0] prod1461;
  logic [40:0] prod365;
  logic        ge2000, ge2100;
  logic [4:0]  c100;
  logic [2:0]  c400;
  logic [20:0] yr_days;
  logic [19:0] doy_full;
  logic        ge153, ge306;
  logic [8:0]  r_full;
  logic [10:0] r_x10;
  logic [22:0] prod305;
  logic [8:0]  mstart;
  logic [9:0]  day_full;
  logic [4:0]  mo2;
  logic        wrap;

  // 400-year correction is 4 or 5 over the input range
  assign q400 = (daynum_i >= 20'(5 * s2cd_pkg::Days400Y - 1)) ? 3'd5 : 3'd4;
  // 100-year correction is 19..21 over the input range
  assign q100 = 5'd19 + 5'(t0_q >= 20'(20 * s2cd_pkg::Days100Y))
                      + 5'(t0_q >= 20'(21 * s2cd_pkg::Days100Y));

  assign x1461    = t1_q + 20'd1;
  assign prod1461 = 41'(x1461) * 41'(s2cd_pkg::Div1461Recip[20:0]);
  assign prod365  = 41'(t2_q) * 41'(s2cd_pkg::Div365Recip[20:0]);

  assign ge2000  = yr7_q >= 12'd2000;
  assign ge2100  = yr7_q >= 12'd2100;
  assign c100    = 5'd19 + 5'(ge2000) + 5'(ge2100);
  assign c400    = 3'd4 + 3'(ge2000);
  assign yr_days = 21'(yr7_q) * 21'(s2cd_pkg::Days1Y);

  assign doy_full = dn8_q - p8_q - 20'(corr8_q);

  assign ge153  = doy9_q >= 9'(s2cd_pkg::Days5Mon);
  assign ge306  = doy9_q >= 9'(2 * s2cd_pkg::Days5Mon);
  assign r_full = doy9_q - (ge306 ? 9'(2 * s2cd_pkg::Days5Mon)
                                  : (ge153 ? 9'(s2cd_pkg::Days5Mon) : 9'd0));

  assign r_x10   = 11'(r10_q) * 11'd10;
  assign prod305 = 23'(r_x10) * 23'(s2cd_pkg::Div305Recip[11:0]);

  assign mstart              = s2cd_pkg::month_start(mo11_q);
  assign day_full            = 10'(doy11_q) + 10'd1 - 10'(mstart);
  assign mo2                 = 5'(mo11_q) + 5'd2;
  assign wrap                = mo2 >= 5'd12;
  assign date_d.day_of_month = day_full[4:0];
  assign date_d.year         = yr11_q + 12'(wrap);
  assign date_d.month        = wrap ? 4'(mo2 - 5'd11) : 4'(mo2 + 5'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[s2cd_pkg::CivilLatency-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q    <= daynum_i - 20'(q400);
    dn3_q   <= daynum_i;
    t1_q    <= t0_q + 20'(q100);
    dn4_q   <= dn3_q;
    q4_q    <= prod1461[s2cd_pkg::Div1461Shift +: 10];
    t1b_q   <= t1_q;
    dn5_q   <= dn4_q;
    t2_q    <= t1b_q - 20'(q4_q);
    dn6_q   <= dn5_q;
    yr7_q   <= prod365[s2cd_pkg::Div365Shift +: 12];
    dn7_q   <= dn6_q;
    p8_q    <= yr_days[19:0];
    corr8_q <= 10'(yr7_q[11:2]) - 10'(c100) + 10'(c400);
    yr8_q   <= yr7_q;
    dn8_q   <= dn7_q;
    doy9_q  <= doy_full[8:0];
    yr9_q   <= yr8_q;
    q10_q   <= 2'(ge153) + 2'(ge306);
    r10_q   <= r_full[7:0];
    doy10_q <= doy9_q;
    yr10_q  <= yr9_q;
    mo11_q  <= 4'(q10_q) * 4'd5 + 4'(prod305[s2cd_pkg::Div305Shift +: 3]);
    doy11_q <= doy10_q;
    yr11_q  <= yr10_q;
    date_q  <= date_d;
  end

  assign valid_o = vld_q[s2cd_pkg::CivilLatency-1];
  assign date_o  = date_q;

endmodule

/* sv/seconds_to_calendar_date_unit.sv */
// Top level: seconds since 1993-01-01 to Gregorian date and time of day.
//
//   channel  | ports                                   | transfer
//   ---------+-----------------------------------------+---------------------------
//   command  | start_i, busy_o, seconds_count_i        | start_i high, busy_o low
//   result   | done_o, year_o, month_o, day_of_month_o,| done_o high, one cycle
//            | hour_o, minute_o, second_o              |
//
// One item per cycle; each result passes 2 stages day split, then 10 stages
// day number to date; time of day runs alongside.
// busy_o stays low: the result side takes every result, so nothing stalls.
// Reset clears only the valid bits; results come out in command order.
`timescale 1ns / 1ps

module seconds_to_calendar_date_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] seconds_count_i,
  output logic        done_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic             split_vld;
  s2cd_pkg::split_t split;
  s2cd_pkg::tod_t   tod;
  s2cd_pkg::date_t  date;

  assign busy_o = 1'b0;

  s2cd_day_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .secs_i  (seconds_count_i),
    .valid_o (split_vld),
    .split_o (split)
  );

  s2cd_tod u_tod (
    .clk_i (clk_i),
    .rem_i (split.rem),
    .tod_o (tod)
  );

  s2cd_civil u_civil (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (split_vld),
    .daynum_i (split.daynum),
    .valid_o  (done_o),
    .date_o   (date)
  );

  assign year_o         = date.year;
  assign month_o        = date.month;
  assign day_of_month_o = date.day_of_month;
  assign hour_o         = tod.hour;
  assign minute_o       = tod.minute;
  assign second_o       = tod.second;

endmodule

/* tb/sv/seconds_to_calendar_date_unit_test.sv */
// Testbench for seconds_to_calendar_date_unit: random and directed timestamps checked against a date predictor.
`timescale 1ns / 1ps

module seconds_to_calendar_date_unit_test;

  localparam int unsigned DaySeconds   = 86400;
  localparam int unsigned MarchEpochDn = 727869;  // March-based day number of 1993-01-01
  localparam int unsigned Cycle400Days = 146097;
  localparam int unsigned Cycle100Days = 36524;
  localparam int unsigned Cycle4Days   = 1461;
  localparam int unsigned YearDays     = 365;
  localparam int unsigned FiveMonDays  = 153;
  localparam int unsigned MaxDay       = 49709;   // last whole day below 2^32 seconds
  localparam int unsigned MaxGap       = 12;
  localparam int unsigned ResultDelay  = 12;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned RandomItems  = 1950;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_time_t;

  typedef struct {
    logic [31:0] secs;
    int unsigned gap;
  } stamp_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] seconds_count_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  stamp_item_t stamp_q[$];
  civil_time_t expected_dates_q[$];
  int          gap_left = -1;
  int unsigned stamps_total = 0;
  int unsigned transfers_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_cnt = 0;

  seconds_to_calendar_date_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .seconds_count_i(seconds_count_i),
    .done_o         (done_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic civil_time_t civil_time_of(input logic [31:0] secs);
    int unsigned dn, t, yr, doy, mo, dy, rem;
    civil_time_t res;
    dn  = secs / DaySeconds + MarchEpochDn;
    t   = dn - (dn + 1) / Cycle400Days;
    t   = t + t / Cycle100Days;
    t   = t - (t + 1) / Cycle4Days;
    yr  = t / YearDays;
    doy = dn - yr * YearDays - yr / 4 + yr / 100 - yr / 400;
    // March-based month from the 153-day five-month pattern
    mo  = (doy / FiveMonDays) * 5 + (10 * (doy % FiveMonDays)) / 305;
    dy  = 1 + doy - (mo * 306 + 5) / 10;
    mo  = mo + 2;
    yr  = yr + mo / 12;
    mo  = mo % 12 + 1;
    rem = secs % DaySeconds;
    res.year         = 12'(yr);
    res.month        = 4'(mo);
    res.day_of_month = 5'(dy);
    res.hour         = 5'(rem / 3600);
    res.minute       = 6'((rem / 60) % 60);
    res.second       = 6'(rem % 60);
    return res;
  endfunction

  task automatic add_stamp(input logic [31:0] secs, input int unsigned gap);
    stamp_item_t item;
    item.secs = secs;
    item.gap  = gap;
    stamp_q.push_back(item);
    stamps_total++;
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // Driver: one transfer per queued timestamp, after its drawn gap.
  always @(posedge clk_i) begin
    stamp_item_t next_stamp;
    if (rst_ni && (!start_i || !busy_o)) begin
      if (stamp_q.size() == 0) begin
        start_i <= 1'b0;
      end else begin
        if (gap_left < 0) gap_left = stamp_q[0].gap;
        if (gap_left > 0) begin
          start_i <= 1'b0;
          gap_left--;
        end else begin
          next_stamp = stamp_q.pop_front();
          start_i <= 1'b1;
          seconds_count_i <= next_stamp.secs;
          gap_left = -1;
        end
      end
    end
  end

  // Monitor: checks results, records new transfers, runs the watchdog.
  always @(posedge clk_i) begin
    civil_time_t exp_date;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_dates_q.size() == 0) begin
          $error("unexpected result: year %0d month %0d day %0d", year_o, month_o,
                 day_of_month_o);
          fail_cnt++;
        end else begin
          exp_date = expected_dates_q.pop_front();
          check_field("year", exp_date.year, year_o);
          check_field("month", exp_date.month, month_o);
          check_field("day_of_month", exp_date.day_of_month, day_of_month_o);
          check_field("hour", exp_date.hour, hour_o);
          check_field("minute", exp_date.minute, minute_o);
          check_field("second", exp_date.second, second_o);
        end
      end
      if (start_i && !busy_o) begin
        expected_dates_q.push_back(civil_time_of(seconds_count_i));
        transfers_seen++;
      end
      if (done_o || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned day, rem, gap;
    bit          burst;

    // directed: field extremes, day/month/year edges, leap and non-leap centuries
    add_stamp(32'd0, 0);
    add_stamp(32'd1, 0);
    add_stamp(32'd59, 1);
    add_stamp(32'd60, 0);
    add_stamp(32'd3599, 3);
    add_stamp(32'd3600, 0);
    add_stamp(32'd86399, 0);
    add_stamp(32'd86400, MaxGap);
    add_stamp(32'd31535999, 0);                // 1993-12-31 23:59:59
    add_stamp(32'd31536000, 0);                // 1994-01-01
    add_stamp(32'd1154 * 32'd86400, 2);        // 1996-02-29
    add_stamp(32'd1155 * 32'd86400 - 1, 0);
    add_stamp(32'd1155 * 32'd86400, 0);        // 1996-03-01
    add_stamp(32'd2615 * 32'd86400, 5);        // 2000-02-29
    add_stamp(32'd2616 * 32'd86400, 0);        // 2000-03-01
    add_stamp(32'd39139 * 32'd86400 + 86399, 0);  // 2100-02-28 23:59:59
    add_stamp(32'd39140 * 32'd86400, 0);       // 2100-03-01
    add_stamp(32'hAAAA_AAAA, 0);
    add_stamp(32'h5555_5555, 7);
    add_stamp(32'h7FFF_FFFF, 0);
    add_stamp(32'h8000_0000, 0);
    add_stamp(32'hFFFF_FFFE, 0);
    add_stamp(32'hFFFF_FFFF, 0);

    burst = 1'b0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, MaxGap);
      case ($urandom_range(0, 4))
        0, 1: add_stamp($urandom(), gap);
        2: begin
          day = $urandom_range(0, MaxDay);
          rem = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(86397, 86399);
          add_stamp(day * DaySeconds + rem, gap);
        end
        3: begin
          // late February / early March of a random year
          day = $urandom_range(0, 135) * YearDays + $urandom_range(0, 140) / 4
                + $urandom_range(55, 62);
          if (day > MaxDay) day = MaxDay;
          add_stamp(day * DaySeconds + $urandom_range(0, DaySeconds - 1), gap);
        end
        default: add_stamp(32'hFFFF_FFFF - $urandom_range(0, 200000000), gap);
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (transfers_seen < stamps_total || expected_dates_q.size() != 0) @(posedge clk_i);
    repeat (ResultDelay + 4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
